@@ rtl/core/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Holds the operation codes, status codes and beat structs, plus the
// per-cell command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    // default number of cells in the row
    localparam int DEPTH_DEFAULT = 16;

    localparam int DATA_W   = 32;
    localparam int FILL_W   = 5;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    // operation codes; unused codes act as a plain read
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_REAR  = 3'd3,
        OP_READ      = 3'd4
    } op_t;

    // status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_DEL_EMPTY = 2'd1,
        ST_INS_FULL  = 2'd2
    } status_t;

    // request beat
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
    } req_t;

    // result beat
    typedef struct packed {
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic [FILL_W-1:0]        fill_count;
        logic                     is_empty;
        logic                     is_full;
        logic [STATUS_W-1:0]      status;
    } rsp_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic shift_back;   // insert at front: each cell takes its front neighbor
        logic shift_fwd;    // delete at front: each cell takes its rear neighbor
        logic push_tail;    // insert at rear: first empty cell loads the value
        logic pop_tail;     // delete at rear: last valid cell drops out
    } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/double_ended_queue_unit.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_unit: double-ended queue of signed 32-bit words
// A row of DEPTH cells kept packed toward the front; front inserts and
// deletes shift the whole row, rear ones touch the boundary cell only.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------
//   request  | in        | start high, busy low | req (op, value)
//   result   | out       | done, one cycle    | rsp (values, count, flags)
//
// An accepted request updates the cells at that edge; its result is on rsp
// with done high in the following cycle.
// busy is high during the result cycle, which sets the rate.
// Reset empties the row at once through the cell valid bits.
// The receiver cannot stall: done lasts exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                start,
    output logic               busy,
    input  wire deq_pkg::req_t req,
    output logic               done,
    output deq_pkg::rsp_t      rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [deq_pkg::DATA_W-1:0] cell_data  [DEPTH];
    logic [DEPTH-1:0]           cell_valid;
    logic [DEPTH-1:0]           cell_last;
    logic [deq_pkg::DATA_W-1:0] cell_prev_data [DEPTH];
    logic [DEPTH-1:0]           cell_prev_valid;
    logic [deq_pkg::DATA_W-1:0] cell_next_data [DEPTH];
    logic [DEPTH-1:0]           cell_next_valid;

    deq_pkg::cell_cmd_t cmd;
    logic               accept;
    logic               is_full_now;
    logic               is_empty_now;

    logic                     done_reg;
    logic                     done_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [deq_pkg::STATUS_W-1:0] status_reg;
    logic [deq_pkg::STATUS_W-1:0] status_next;

    logic [deq_pkg::DATA_W-1:0] rear_word;
    logic [CNT_W+deq_pkg::FILL_W-1:0] count_wide;

    assign accept       = start && !busy;
    assign is_full_now  = cell_valid[DEPTH-1];
    assign is_empty_now = !cell_valid[0];

    // decode the request into a row command, refusing bad inserts and deletes
    always_comb
    begin
        cmd         = '0;
        status_next = deq_pkg::ST_OK;
        count_next  = count_reg;
        if (accept)
        begin
            case (req.op)
                deq_pkg::OP_INS_FRONT:
                begin
                    if (is_full_now)
                    begin
                        status_next = deq_pkg::ST_INS_FULL;
                    end
                    else
                    begin
                        cmd.shift_back = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                    end
                end
                deq_pkg::OP_INS_REAR:
                begin
                    if (is_full_now)
                    begin
                        status_next = deq_pkg::ST_INS_FULL;
                    end
                    else
                    begin
                        cmd.push_tail = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                deq_pkg::OP_DEL_FRONT:
                begin
                    if (is_empty_now)
                    begin
                        status_next = deq_pkg::ST_DEL_EMPTY;
                    end
                    else
                    begin
                        cmd.shift_fwd = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                deq_pkg::OP_DEL_REAR:
                begin
                    if (is_empty_now)
                    begin
                        status_next = deq_pkg::ST_DEL_EMPTY;
                    end
                    else
                    begin
                        cmd.pop_tail = 1'b1;
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = deq_pkg::ST_OK;
                end
            endcase
        end
    end

    // neighbor wiring; the front end sees the incoming value as a valid word
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
            begin
                cell_prev_data[i]  = req.value;
                cell_prev_valid[i] = 1'b1;
            end
            else
            begin
                cell_prev_data[i]  = cell_data[i-1];
                cell_prev_valid[i] = cell_valid[i-1];
            end
            if (i == DEPTH - 1)
            begin
                cell_next_data[i]  = '0;
                cell_next_valid[i] = 1'b0;
            end
            else
            begin
                cell_next_data[i]  = cell_data[i+1];
                cell_next_valid[i] = cell_valid[i+1];
            end
        end
    end

    // row of cells
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        deq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .tail_data  (req.value),
            .prev_data  (cell_prev_data[g]),
            .prev_valid (cell_prev_valid[g]),
            .next_data  (cell_next_data[g]),
            .next_valid (cell_next_valid[g]),
            .data       (cell_data[g]),
            .valid      (cell_valid[g]),
            .is_last    (cell_last[g])
        );
    end

    // result strobe, fill count and status
    assign done_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            count_reg  <= '0;
            status_reg <= deq_pkg::ST_OK;
        end
        else
        begin
            done_reg   <= done_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // pick the rear word from the one cell flagged as last
    always_comb
    begin
        rear_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_word = rear_word | (cell_data[i] & {deq_pkg::DATA_W{cell_last[i]}});
        end
    end

    assign count_wide = {{deq_pkg::FILL_W{1'b0}}, count_reg};

    // result beat
    always_comb
    begin
        rsp.front_value = is_empty_now ? '1 : cell_data[0];
        rsp.rear_value  = is_empty_now ? '1 : rear_word;
        rsp.fill_count  = count_wide[deq_pkg::FILL_W-1:0];
        rsp.is_empty    = is_empty_now;
        rsp.is_full     = is_full_now;
        rsp.status      = status_reg;
    end

    assign busy = done_reg;
    assign done = done_reg;

    // each accepted request gives exactly one result in the next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(start && !busy))
        else $error("result strobe does not follow accepted request");

    // occupied cells stay packed toward the front
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (((cell_valid >> 1) & ~cell_valid) == '0))
        else $error("gap in occupied cells");

    // empty flag agrees with the fill count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        is_empty_now == (count_reg == '0))
        else $error("empty flag and count disagree");

    // full flag agrees with the fill count
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        is_full_now == (count_reg == CNT_W'(DEPTH)))
        else $error("full flag and count disagree");

endmodule

`default_nettype wire

@@ rtl/core/deq_cell.sv @@
// ----------------------------------------------------------------------------
// deq_cell: one storage cell of the queue row
// Holds one word and a valid bit; moves data to or from its neighbors
// according to the broadcast command.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire deq_pkg::cell_cmd_t         cmd,
    input  wire logic [deq_pkg::DATA_W-1:0] tail_data,
    input  wire logic [deq_pkg::DATA_W-1:0] prev_data,
    input  wire logic                       prev_valid,
    input  wire logic [deq_pkg::DATA_W-1:0] next_data,
    input  wire logic                       next_valid,
    output logic [deq_pkg::DATA_W-1:0]      data,
    output logic                            valid,
    output logic                            is_last
);

    logic [deq_pkg::DATA_W-1:0] data_reg;
    logic [deq_pkg::DATA_W-1:0] data_next;
    logic                       valid_reg;
    logic                       valid_next;

    // next contents from the command and the neighbors
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (cmd.shift_back)
        begin
            data_next  = prev_data;
            valid_next = prev_valid;
        end
        else if (cmd.shift_fwd)
        begin
            data_next  = next_data;
            valid_next = next_valid;
        end
        else if (cmd.push_tail)
        begin
            if (!valid_reg && prev_valid)
            begin
                data_next  = tail_data;
                valid_next = 1'b1;
            end
        end
        else if (cmd.pop_tail)
        begin
            if (valid_reg && !next_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign valid   = valid_reg;
    assign is_last = valid_reg && !next_valid;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for double_ended_queue_unit
// Walks a directed table of deque operations (empty and full edges, unused
// op codes, refused inserts and deletes, a stored minus one), then about
// 700 random operations that drift between filling and draining the queue.
// Every result beat is compared field by field against the pinned table
// values or a ring-buffer predictor run at the input beat's acceptance edge.
// ----------------------------------------------------------------------------

module testbench;

    import deq_pkg::*;

    localparam int DEPTH          = deq_pkg::DEPTH_DEFAULT;
    localparam int CLK_PERIOD     = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BEATS    = 175;

    // op codes outside the enum; the block treats them as plain reads
    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;

    // empty marker and word extremes
    localparam logic [DATA_W-1:0] NONE = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] MAXV = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] MINV = 32'h8000_0000;

    // one row of the directed table; reps repeats the beat with value + k
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [DATA_W-1:0]   value;
        int                  reps;
        bit                  pinned;
        logic [DATA_W-1:0]   want_front;
        logic [DATA_W-1:0]   want_rear;
        logic [FILL_W-1:0]   want_fill;
        logic                want_empty;
        logic                want_full;
        logic [STATUS_W-1:0] want_status;
    } stim_row_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    rsp_t  rsp;

    // predictor state: ring of slots, front index, index after rear, fill
    logic [DATA_W-1:0] ring_slot [DEPTH];
    int                ring_head;
    int                ring_tail;
    int                ring_count;

    rsp_t      pending_results [$];
    bit        cur_pinned;
    rsp_t      cur_want;
    bit        took_beat;
    rsp_t      predicted;
    rsp_t      oldest;
    int        mismatch_count;
    int        idle_cycles;
    bit        filling;
    stim_row_t directed_rows [22];

    double_ended_queue_unit #(
        .DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // apply one operation to the predicted deque and return its result beat
    function automatic rsp_t apply_deque_op(req_t beat);
        rsp_t outcome;
        outcome        = '0;
        outcome.status = ST_OK;
        case (beat.op)
            OP_INS_FRONT:
            begin
                if (ring_count == DEPTH)
                    outcome.status = ST_INS_FULL;
                else
                begin
                    ring_head            = (ring_head + DEPTH - 1) % DEPTH;
                    ring_slot[ring_head] = beat.value;
                    ring_count++;
                end
            end
            OP_INS_REAR:
            begin
                if (ring_count == DEPTH)
                    outcome.status = ST_INS_FULL;
                else
                begin
                    ring_slot[ring_tail] = beat.value;
                    ring_tail            = (ring_tail + 1) % DEPTH;
                    ring_count++;
                end
            end
            OP_DEL_FRONT:
            begin
                if (ring_count == 0)
                    outcome.status = ST_DEL_EMPTY;
                else
                begin
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_count--;
                end
            end
            OP_DEL_REAR:
            begin
                if (ring_count == 0)
                    outcome.status = ST_DEL_EMPTY;
                else
                begin
                    ring_tail = (ring_tail + DEPTH - 1) % DEPTH;
                    ring_count--;
                end
            end
            default:
            begin
            end
        endcase
        if (ring_count == 0)
        begin
            outcome.front_value = NONE;
            outcome.rear_value  = NONE;
        end
        else
        begin
            outcome.front_value = ring_slot[ring_head];
            outcome.rear_value  = ring_slot[(ring_tail + DEPTH - 1) % DEPTH];
        end
        outcome.fill_count = FILL_W'(ring_count);
        outcome.is_empty   = (ring_count == 0);
        outcome.is_full    = (ring_count == DEPTH);
        return outcome;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // random word biased toward extremes and the empty marker
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return MAXV;
            1: return MINV;
            2: return NONE;
            3: return '0;
            4: return DATA_W'($urandom_range(255));
            default: return $urandom();
        endcase
    endfunction

    // present one request beat after a random idle gap; returns at the
    // falling edge after acceptance
    task automatic send_beat(input req_t beat, input int idle_pct, input bit pinned,
                             input rsp_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start      <= 1'b1;
        req        <= beat;
        cur_pinned  = pinned;
        cur_want    = want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    // result checking, prediction at acceptance, and the watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took_beat = (start === 1'b1) && (busy === 1'b0);
            if (done === 1'b1)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result beat", rsp.front_value, NONE);
                else
                begin
                    oldest = pending_results.pop_front();
                    if (rsp.front_value !== oldest.front_value)
                        report_mismatch("front_value", rsp.front_value, oldest.front_value);
                    if (rsp.rear_value !== oldest.rear_value)
                        report_mismatch("rear_value", rsp.rear_value, oldest.rear_value);
                    if (rsp.fill_count !== oldest.fill_count)
                        report_mismatch("fill_count", DATA_W'(rsp.fill_count),
                                        DATA_W'(oldest.fill_count));
                    if (rsp.is_empty !== oldest.is_empty)
                        report_mismatch("is_empty", DATA_W'(rsp.is_empty),
                                        DATA_W'(oldest.is_empty));
                    if (rsp.is_full !== oldest.is_full)
                        report_mismatch("is_full", DATA_W'(rsp.is_full),
                                        DATA_W'(oldest.is_full));
                    if (rsp.status !== oldest.status)
                        report_mismatch("status", DATA_W'(rsp.status),
                                        DATA_W'(oldest.status));
                end
            end
            if (took_beat)
            begin
                predicted = apply_deque_op(req);
                pending_results.push_back(cur_pinned ? cur_want : predicted);
            end
            // watchdog on cycles with no beat in either direction
            if (took_beat || done === 1'b1)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        req_t beat;
        rsp_t want;
        stim_row_t row;
        int   idle_pct [4];
        int   roll;
        logic [OP_W-1:0] pick;

        rst_n          = 1'b0;
        start          = 1'b0;
        req            = '0;
        cur_pinned     = 1'b0;
        cur_want       = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        ring_head      = 0;
        ring_tail      = 0;
        ring_count     = 0;
        filling        = 1'b1;
        idle_pct       = '{0, 60, 0, 22};

        // directed table: empty edges, unused codes, extremes, full edges
        directed_rows = '{
            '{OP_READ,      32'h0,    1,  1'b1, NONE, NONE, 5'd0, 1'b1, 1'b0, ST_OK},
            '{OP_DEL_FRONT, 32'h0,    1,  1'b1, NONE, NONE, 5'd0, 1'b1, 1'b0, ST_DEL_EMPTY},
            '{OP_DEL_REAR,  32'h0,    1,  1'b1, NONE, NONE, 5'd0, 1'b1, 1'b0, ST_DEL_EMPTY},
            '{OP_SPARE_LO,  32'h0F0F0F0F, 1, 1'b1, NONE, NONE, 5'd0, 1'b1, 1'b0, ST_OK},
            '{OP_SPARE_MID, 32'hF0F0F0F0, 1, 1'b1, NONE, NONE, 5'd0, 1'b1, 1'b0, ST_OK},
            '{OP_SPARE_HI,  NONE,     1,  1'b1, NONE, NONE, 5'd0, 1'b1, 1'b0, ST_OK},
            '{OP_INS_FRONT, MAXV,     1,  1'b1, MAXV, MAXV, 5'd1, 1'b0, 1'b0, ST_OK},
            '{OP_INS_REAR,  MINV,     1,  1'b1, MAXV, MINV, 5'd2, 1'b0, 1'b0, ST_OK},
            // stored minus one at the front, queue not empty
            '{OP_INS_FRONT, NONE,     1,  1'b1, NONE, MINV, 5'd3, 1'b0, 1'b0, ST_OK},
            '{OP_INS_REAR,  32'h0,    1,  1'b0, '0, '0, '0, 1'b0, 1'b0, ST_OK},
            '{OP_READ,      32'h0,    1,  1'b0, '0, '0, '0, 1'b0, 1'b0, ST_OK},
            '{OP_DEL_REAR,  32'h0,    1,  1'b0, '0, '0, '0, 1'b0, 1'b0, ST_OK},
            '{OP_DEL_FRONT, 32'h0,    1,  1'b0, '0, '0, '0, 1'b0, 1'b0, ST_OK},
            // fill to the brim with 0x100 .. 0x10d at the rear
            '{OP_INS_REAR,  32'h100,  14, 1'b0, '0, '0, '0, 1'b0, 1'b0, ST_OK},
            '{OP_INS_FRONT, 32'h5A5A5A5A, 1, 1'b1, MAXV, 32'h10D, 5'd16, 1'b0, 1'b1,
              ST_INS_FULL},
            '{OP_INS_REAR,  32'hA5A5A5A5, 1, 1'b1, MAXV, 32'h10D, 5'd16, 1'b0, 1'b1,
              ST_INS_FULL},
            '{OP_READ,      32'h0,    1,  1'b1, MAXV, 32'h10D, 5'd16, 1'b0, 1'b1, ST_OK},
            // drain from both ends
            '{OP_DEL_REAR,  32'h0,    8,  1'b0, '0, '0, '0, 1'b0, 1'b0, ST_OK},
            '{OP_DEL_FRONT, 32'h0,    8,  1'b0, '0, '0, '0, 1'b0, 1'b0, ST_OK},
            '{OP_DEL_REAR,  32'h0,    1,  1'b1, NONE, NONE, 5'd0, 1'b1, 1'b0, ST_DEL_EMPTY},
            '{OP_INS_REAR,  NONE,     1,  1'b1, NONE, NONE, 5'd1, 1'b0, 1'b0, ST_OK},
            '{OP_DEL_FRONT, 32'h0,    1,  1'b1, NONE, NONE, 5'd0, 1'b1, 1'b0, ST_OK}
        };

        // reset
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            for (int k = 0; k < row.reps; k++)
            begin
                beat.op            = row.op;
                beat.value         = row.value + DATA_W'(k);
                want.front_value   = row.want_front;
                want.rear_value    = row.want_rear;
                want.fill_count    = row.want_fill;
                want.is_empty      = row.want_empty;
                want.is_full       = row.want_full;
                want.status        = row.want_status;
                send_beat(beat, 0, row.pinned, want);
            end
        end

        // random part: drift between filling and draining, with some noise
        for (int phase = 0; phase < 4; phase++)
        begin
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (ring_count == DEPTH && $urandom_range(3) == 0)
                    filling = 1'b0;
                if (ring_count == 0 && $urandom_range(3) == 0)
                    filling = 1'b1;
                if ($urandom_range(31) == 0)
                    filling = !filling;
                roll = $urandom_range(99);
                if (roll < 6)
                    pick = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
                else if (roll < 12)
                    pick = OP_READ;
                else if ((roll < 80) == filling)
                    pick = $urandom_range(1) ? OP_INS_FRONT : OP_INS_REAR;
                else
                    pick = $urandom_range(1) ? OP_DEL_FRONT : OP_DEL_REAR;
                beat.op    = pick;
                beat.value = pick_value();
                send_beat(beat, idle_pct[phase], 1'b0, '0);
            end
        end

        // drain and finish
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
